>>> rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and codes for the tcp client connection tracker.
// ----------------------------------------------------------------------------
package tcf_pkg;

   typedef enum logic [1:0] {
      CONN_CLOSED      = 2'd0,
      CONN_SYN_SENT    = 2'd1,
      CONN_ESTABLISHED = 2'd2,
      CONN_CLOSE_WAIT  = 2'd3
   } conn_state_type;

   localparam logic [1:0] REQ_OPEN    = 2'd0;
   localparam logic [1:0] REQ_CLOSE   = 2'd1;
   localparam logic [1:0] REQ_SEGMENT = 2'd2;

   localparam logic [5:0] FLAG_FIN = 6'h01;
   localparam logic [5:0] FLAG_SYN = 6'h02;
   localparam logic [5:0] FLAG_PSH = 6'h08;
   localparam logic [5:0] FLAG_ACK = 6'h10;

   // payload length lies in -120 .. 65535, held as 17-bit two's complement
   localparam int LEN_WIDTH = 17;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [31:0]          initial_seq;
      logic                 seg_is_tcp;
      logic [5:0]           seg_flags;
      logic [31:0]          seg_seq;
      logic [31:0]          seg_ack;
      logic [LEN_WIDTH-1:0] payload_len;
   } item_type;

   typedef struct packed {
      logic        send_valid;
      logic [5:0]  send_flags;
      logic [31:0] send_seq;
      logic [31:0] send_ack;
      logic [1:0]  conn_state;
      logic        is_last;
   } result_type;

   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } step_type;

endpackage

>>> rtl/tcf_req_if.sv
// ----------------------------------------------------------------------------
// tcf_req_if
// Request channel: open, close or received segment words.
// ----------------------------------------------------------------------------
interface tcf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] initial_seq;
   logic        seg_is_tcp;
   logic [5:0]  seg_flags;
   logic [31:0] seg_seq;
   logic [31:0] seg_ack;
   logic [15:0] ip_total_length;
   logic [3:0]  ip_header_words;
   logic [3:0]  tcp_header_words;

   modport source (
      output valid, req_type, initial_seq, seg_is_tcp, seg_flags, seg_seq, seg_ack,
             ip_total_length, ip_header_words, tcp_header_words,
      input  ready
   );
   modport sink (
      input  valid, req_type, initial_seq, seg_is_tcp, seg_flags, seg_seq, seg_ack,
             ip_total_length, ip_header_words, tcp_header_words,
      output ready
   );
endinterface

>>> rtl/tcf_rsp_if.sv
// ----------------------------------------------------------------------------
// tcf_rsp_if
// Response channel: transmit decisions and connection state.
// ----------------------------------------------------------------------------
interface tcf_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_valid;
   logic [5:0]  send_flags;
   logic [31:0] send_seq;
   logic [31:0] send_ack;
   logic [1:0]  conn_state;
   logic        is_last;

   modport source (
      output valid, send_valid, send_flags, send_seq, send_ack, conn_state, is_last,
      input  ready
   );
   modport sink (
      input  valid, send_valid, send_flags, send_seq, send_ack, conn_state, is_last,
      output ready
   );
endinterface

>>> rtl/tcf_conn.sv
// ----------------------------------------------------------------------------
// tcf_conn
// Connection state, sequence and ack registers plus the per-word decision.
// ----------------------------------------------------------------------------
module tcf_conn import tcf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  item_type item,
   output step_type step
);

   conn_state_type state_ff, state_in;
   logic [31:0]    seq_ff, seq_in;
   logic [31:0]    ack_ff, ack_in;

   logic           sent_hs, sent_more;
   result_type     hs_res, more_res, empty_res;
   logic [31:0]    len_ext;
   logic           flag_ack, flag_syn, flag_psh, flag_fin;

   function automatic result_type make_result(logic [5:0] flags, logic [31:0] seq,
                                              logic [31:0] ack, conn_state_type st);
      result_type r;
      r.send_valid = 1'b1;
      r.send_flags = flags;
      r.send_seq   = seq;
      r.send_ack   = ack;
      r.conn_state = 2'(st);
      r.is_last    = 1'b0;
      return r;
   endfunction

   assign len_ext  = {{(32-LEN_WIDTH){item.payload_len[LEN_WIDTH-1]}}, item.payload_len};
   assign flag_ack = (item.seg_flags & FLAG_ACK) != 6'd0;
   assign flag_syn = (item.seg_flags & FLAG_SYN) != 6'd0;
   assign flag_psh = (item.seg_flags & FLAG_PSH) != 6'd0;
   assign flag_fin = (item.seg_flags & FLAG_FIN) != 6'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONN_CLOSED;
         seq_ff   <= '0;
         ack_ff   <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
         ack_ff   <= ack_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      seq_in    = seq_ff;
      ack_in    = ack_ff;
      sent_hs   = 1'b0;
      sent_more = 1'b0;
      hs_res    = '0;
      more_res  = '0;
      empty_res = '0;
      step      = '0;

      case (item.req_type)
         REQ_OPEN: begin
            if (state_ff == CONN_CLOSED || state_ff == CONN_SYN_SENT) begin
               seq_in = item.initial_seq;
               ack_in = '0;
            end
            state_in = CONN_SYN_SENT;
            hs_res   = make_result(FLAG_SYN, seq_in, ack_in, state_in);
            sent_hs  = 1'b1;
            seq_in   = seq_in + 32'd1;
         end
         REQ_CLOSE: begin
            if (state_ff == CONN_CLOSED || state_ff == CONN_SYN_SENT) begin
               seq_in = item.initial_seq;
               ack_in = '0;
            end
            state_in = CONN_CLOSE_WAIT;
            hs_res   = make_result(FLAG_FIN | FLAG_ACK, seq_in, ack_in, state_in);
            sent_hs  = 1'b1;
         end
         REQ_SEGMENT: begin
            if (item.seg_is_tcp) begin
               // handshake completes on a syn-ack that acks our syn
               if (state_in == CONN_SYN_SENT && flag_ack && flag_syn &&
                   item.seg_ack == seq_in) begin
                  ack_in   = item.seg_seq + 32'd1;
                  state_in = CONN_ESTABLISHED;
                  hs_res   = make_result(FLAG_ACK, seq_in, ack_in, state_in);
                  sent_hs  = 1'b1;
               end
               if (state_in == CONN_ESTABLISHED && flag_ack) begin
                  seq_in = item.seg_ack;
                  if (flag_psh) begin
                     ack_in    = item.seg_seq + len_ext;
                     more_res  = make_result(FLAG_ACK, seq_in, ack_in, state_in);
                     sent_more = 1'b1;
                  end else if (flag_fin) begin
                     ack_in    = item.seg_seq + 32'd1;
                     state_in  = CONN_CLOSED;
                     more_res  = make_result(FLAG_ACK, seq_in, ack_in, state_in);
                     sent_more = 1'b1;
                  end
               end
               if (state_in == CONN_CLOSE_WAIT && flag_ack) begin
                  state_in = CONN_CLOSED;
               end
            end
         end
         default: begin
         end
      endcase

      empty_res.conn_state = 2'(state_in);
      empty_res.is_last    = 1'b1;

      if (sent_hs && sent_more) begin
         step.first          = hs_res;
         step.second         = more_res;
         step.second.is_last = 1'b1;
         step.two            = 1'b1;
      end else if (sent_hs) begin
         step.first         = hs_res;
         step.first.is_last = 1'b1;
      end else if (sent_more) begin
         step.first         = more_res;
         step.first.is_last = 1'b1;
      end else begin
         step.first = empty_res;
      end
   end

endmodule

>>> rtl/tcp_client_connection_fsm.sv
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm
// Client side tcp connection tracker with valid/ready request and response.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch carries open requests, close requests and received segment headers.
//  rsp_ch returns one or two words per request; is_last marks the final one.
//  A word with send_valid low means no segment goes out for that request.
//  A request taken on req_ch is first held in the request register, then
//  decided into the response buffer, from which its first word is offered.
//  Throughput: one request per cycle while each request yields one word and
//  rsp_ch takes every word; a request that yields two words (syn-ack carrying
//  data or fin) holds the two-word response buffer until its words are taken.
//  The request register refills while a response waits, so one request is
//  buffered when rsp_ch stalls; after that req_ch.ready drops.
//  Reset (synchronous) returns to closed with sequence and ack numbers at
//  zero and empties both the request register and the response buffer.
// ----------------------------------------------------------------------------
module tcp_client_connection_fsm import tcf_pkg::*; (
   input logic        clock,
   input logic        reset,
   tcf_req_if.sink    req_ch,
   tcf_rsp_if.source  rsp_ch
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic [1:0] out_cnt_ff, out_cnt_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;

   logic       req_fire, rsp_pop, proc_fire;
   step_type   step;

   assign rsp_pop   = rsp_ch.valid && rsp_ch.ready;
   // decide only when the whole response buffer is free after this cycle
   assign proc_fire = in_valid_ff && (out_cnt_ff == 2'd0 || (out_cnt_ff == 2'd1 && rsp_pop));
   assign req_ch.ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in.req_type    = req_ch.req_type;
      item_in.initial_seq = req_ch.initial_seq;
      item_in.seg_is_tcp  = req_ch.seg_is_tcp;
      item_in.seg_flags   = req_ch.seg_flags;
      item_in.seg_seq     = req_ch.seg_seq;
      item_in.seg_ack     = req_ch.seg_ack;
      item_in.payload_len = {1'b0, req_ch.ip_total_length}
                          - {{(LEN_WIDTH-6){1'b0}}, req_ch.ip_header_words, 2'b00}
                          - {{(LEN_WIDTH-6){1'b0}}, req_ch.tcp_header_words, 2'b00};
   end

   tcf_conn u_conn (
      .clock (clock),
      .reset (reset),
      .fire  (proc_fire),
      .item  (item_ff),
      .step  (step)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      out_cnt_in = out_cnt_ff;
      if (proc_fire) begin
         slot0_in   = step.first;
         slot1_in   = step.second;
         out_cnt_in = step.two ? 2'd2 : 2'd1;
      end else if (rsp_pop) begin
         slot0_in   = slot1_ff;
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_cnt_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_ch.valid      = out_cnt_ff != 2'd0;
   assign rsp_ch.send_valid = slot0_ff.send_valid;
   assign rsp_ch.send_flags = slot0_ff.send_flags;
   assign rsp_ch.send_seq   = slot0_ff.send_seq;
   assign rsp_ch.send_ack   = slot0_ff.send_ack;
   assign rsp_ch.conn_state = slot0_ff.conn_state;
   assign rsp_ch.is_last    = slot0_ff.is_last;

   // a two-word response leaves the first word unmarked and the second marked
   a_two_word_order: assert property (@(posedge clock) disable iff (reset)
      proc_fire && step.two |=> out_cnt_ff == 2'd2 && !slot0_ff.is_last && slot1_ff.is_last)
      else $error("two-word response not ordered correctly");

   // a single buffered word is always the last of its request
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff == 2'd1 |-> slot0_ff.is_last)
      else $error("single buffered word not marked last");

   // an empty decision is never followed by another word
   a_empty_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.send_valid |-> rsp_ch.is_last && out_cnt_ff == 2'd1)
      else $error("empty response word not alone");

   // a word taken from a full buffer leaves it no longer full
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff == 2'd2 |=> out_cnt_ff != 2'd2 || !$past(rsp_pop))
      else $error("response buffer count inconsistent");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tcp client connection tracker. A table of
// open, close and segment requests walks the handshake, data, fin and
// close paths, then randomized requests (mostly well-formed connection
// sequences, some noise) follow. Each response word is compared against the
// word given in the table or a cycle-free connection model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top import tcf_pkg::*; ();

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [5:0] FLAG_RST   = 6'h04;
   localparam logic [5:0] FLAG_URG   = 6'h20;
   localparam bit         TYPED      = 1'b1;
   localparam bit         PREDICTED  = 1'b0;
   localparam int         RANDOM_REQUESTS = 400;
   localparam int         CYCLE_LIMIT     = 200000;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] isn;
      logic        is_tcp;
      logic [5:0]  flags;
      logic [31:0] sseq;
      logic [31:0] sack;
      logic [15:0] total_len;
      logic [3:0]  ip_words;
      logic [3:0]  tcp_words;
   } req_word_type;

   typedef struct {
      req_word_type w;
      bit           typed;
      result_type   want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcf_req_if req_ch ();
   tcf_rsp_if rsp_ch ();

   tcp_client_connection_fsm dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // connection model state
   conn_state_type model_state = CONN_CLOSED;
   logic [31:0]    model_seq   = '0;
   logic [31:0]    model_ack   = '0;

   result_type    predicted_words[$];
   result_type    pending_replies[$];
   table_row_type stimulus_table[$];

   bit no_stall        = 1'b0;
   int mismatch_count  = 0;
   int words_checked   = 0;
   int two_word_count  = 0;
   int requests_sent   = 0;
   int cycle_count     = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch @%0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   function automatic void push_word(input logic [5:0] flags);
      result_type r;
      r.send_valid = 1'b1;
      r.send_flags = flags;
      r.send_seq   = model_seq;
      r.send_ack   = model_ack;
      r.conn_state = model_state;
      r.is_last    = 1'b0;
      predicted_words.push_back(r);
   endfunction

   // advances the connection model by one request and lists its words
   function automatic void predict_reply(input req_word_type w);
      logic [31:0] payload;
      logic        acked;
      result_type  idle_word;
      predicted_words.delete();
      acked = (w.flags & FLAG_ACK) != 6'd0;
      if ((w.kind == REQ_OPEN || w.kind == REQ_CLOSE) &&
          (model_state == CONN_CLOSED || model_state == CONN_SYN_SENT)) begin
         model_seq = w.isn;
         model_ack = '0;
      end
      if (w.kind == REQ_OPEN) begin
         model_state = CONN_SYN_SENT;
         push_word(FLAG_SYN);
         model_seq = model_seq + 32'd1;
      end else if (w.kind == REQ_CLOSE) begin
         model_state = CONN_CLOSE_WAIT;
         push_word(FLAG_FIN | FLAG_ACK);
      end else if (w.kind == REQ_SEGMENT && w.is_tcp) begin
         if (model_state == CONN_SYN_SENT && acked && (w.flags & FLAG_SYN) != 6'd0 &&
             w.sack == model_seq) begin
            model_ack   = w.sseq + 32'd1;
            model_state = CONN_ESTABLISHED;
            push_word(FLAG_ACK);
         end
         if (model_state == CONN_ESTABLISHED && acked) begin
            model_seq = w.sack;
            if ((w.flags & FLAG_PSH) != 6'd0) begin
               // header sizes may exceed the total length, so this wraps
               payload   = {16'd0, w.total_len} - {26'd0, w.ip_words, 2'b00}
                           - {26'd0, w.tcp_words, 2'b00};
               model_ack = w.sseq + payload;
               push_word(FLAG_ACK);
            end else if ((w.flags & FLAG_FIN) != 6'd0) begin
               model_ack   = w.sseq + 32'd1;
               model_state = CONN_CLOSED;
               push_word(FLAG_ACK);
            end
         end
         if (model_state == CONN_CLOSE_WAIT && acked)
            model_state = CONN_CLOSED;
      end
      if (predicted_words.size() == 0) begin
         idle_word = '0;
         idle_word.conn_state = model_state;
         predicted_words.push_back(idle_word);
      end
      predicted_words[predicted_words.size() - 1].is_last = 1'b1;
   endfunction

   function automatic void add_row(
      input logic [1:0] kind, input logic [31:0] isn, input logic is_tcp,
      input logic [5:0] flags, input logic [31:0] sseq, input logic [31:0] sack,
      input logic [15:0] total_len, input logic [3:0] ip_words,
      input logic [3:0] tcp_words, input bit typed, input logic send_valid,
      input logic [5:0] send_flags, input logic [31:0] send_seq,
      input logic [31:0] send_ack, input conn_state_type st);
      table_row_type row;
      row.w.kind       = kind;
      row.w.isn        = isn;
      row.w.is_tcp     = is_tcp;
      row.w.flags      = flags;
      row.w.sseq       = sseq;
      row.w.sack       = sack;
      row.w.total_len  = total_len;
      row.w.ip_words   = ip_words;
      row.w.tcp_words  = tcp_words;
      row.typed        = typed;
      row.want.send_valid = send_valid;
      row.want.send_flags = send_flags;
      row.want.send_seq   = send_seq;
      row.want.send_ack   = send_ack;
      row.want.conn_state = st;
      row.want.is_last    = 1'b1;
      stimulus_table.push_back(row);
   endfunction

   function automatic req_word_type random_request();
      req_word_type w;
      int           pick;
      w.kind      = REQ_SEGMENT;
      w.isn       = $urandom();
      w.is_tcp    = 1'b1;
      w.flags     = 6'($urandom());
      w.sseq      = $urandom();
      w.sack      = $urandom();
      w.total_len = 16'($urandom());
      w.ip_words  = 4'($urandom());
      w.tcp_words = 4'($urandom());
      pick = $urandom_range(0, 99);
      // noise: any code, any protocol, any header
      if (pick < 25) begin
         w.kind   = 2'($urandom());
         w.is_tcp = 1'($urandom());
         return w;
      end
      if ($urandom_range(0, 3) != 0) begin
         w.ip_words  = 4'($urandom_range(5, 15));
         w.tcp_words = 4'($urandom_range(5, 15));
         w.total_len = 16'(4 * (w.ip_words + w.tcp_words) + $urandom_range(0, 1460));
      end
      case (model_state)
         CONN_CLOSED: begin
            w.kind = ($urandom_range(0, 9) < 8) ? REQ_OPEN : REQ_CLOSE;
         end
         CONN_SYN_SENT: begin
            if ($urandom_range(0, 9) == 0)
               w.kind = REQ_OPEN;
            else begin
               w.flags = (6'($urandom()) & (FLAG_FIN | FLAG_PSH | FLAG_RST | FLAG_URG))
                         | FLAG_SYN | FLAG_ACK;
               if ($urandom_range(0, 9) != 0)
                  w.sack = model_seq;
            end
         end
         CONN_ESTABLISHED: begin
            if ($urandom_range(0, 19) == 0)
               w.kind = REQ_CLOSE;
            else if ($urandom_range(0, 9) != 0)
               w.flags = w.flags | FLAG_ACK;
         end
         default: begin
            if ($urandom_range(0, 3) == 0)
               w.kind = REQ_OPEN;
            else
               w.flags = w.flags | FLAG_ACK;
         end
      endcase
      return w;
   endfunction

   task automatic send_request(input req_word_type w, input bit typed,
                               input result_type want);
      if (!no_stall) begin
         while ($urandom_range(0, 99) < 17) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid            <= 1'b1;
      req_ch.req_type         <= w.kind;
      req_ch.initial_seq      <= w.isn;
      req_ch.seg_is_tcp       <= w.is_tcp;
      req_ch.seg_flags        <= w.flags;
      req_ch.seg_seq          <= w.sseq;
      req_ch.seg_ack          <= w.sack;
      req_ch.ip_total_length  <= w.total_len;
      req_ch.ip_header_words  <= w.ip_words;
      req_ch.tcp_header_words <= w.tcp_words;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      predict_reply(w);
      if (predicted_words.size() == 2)
         two_word_count++;
      if (typed)
         pending_replies.push_back(want);
      else
         foreach (predicted_words[i]) pending_replies.push_back(predicted_words[i]);
   endtask

   // response side: check each accepted word, then pick next ready
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_checked++;
         if (pending_replies.size() == 0)
            report_mismatch("word with nothing pending", 32'd1, 32'd0);
         else begin
            want = pending_replies.pop_front();
            if (rsp_ch.send_valid !== want.send_valid)
               report_mismatch("send_valid", 32'(rsp_ch.send_valid),
                               32'(want.send_valid));
            if (rsp_ch.send_flags !== want.send_flags)
               report_mismatch("send_flags", 32'(rsp_ch.send_flags),
                               32'(want.send_flags));
            if (rsp_ch.send_seq !== want.send_seq)
               report_mismatch("send_seq", rsp_ch.send_seq, want.send_seq);
            if (rsp_ch.send_ack !== want.send_ack)
               report_mismatch("send_ack", rsp_ch.send_ack, want.send_ack);
            if (rsp_ch.conn_state !== want.conn_state)
               report_mismatch("conn_state", 32'(rsp_ch.conn_state),
                               32'(want.conn_state));
            if (rsp_ch.is_last !== want.is_last)
               report_mismatch("is_last", 32'(rsp_ch.is_last), 32'(want.is_last));
         end
      end
      rsp_ch.ready <= no_stall || ($urandom_range(0, 99) >= 17);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies pending", cycle_count,
                  pending_replies.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      req_word_type w;
      result_type   none;
      none = '0;
      req_ch.valid            <= 1'b0;
      req_ch.req_type         <= REQ_OPEN;
      req_ch.initial_seq      <= '0;
      req_ch.seg_is_tcp       <= 1'b0;
      req_ch.seg_flags        <= '0;
      req_ch.seg_seq          <= '0;
      req_ch.seg_ack          <= '0;
      req_ch.ip_total_length  <= '0;
      req_ch.ip_header_words  <= '0;
      req_ch.tcp_header_words <= '0;

      // closed: ignored and empty requests
      add_row(REQ_SEGMENT, 32'hFFFF_FFFF, 1'b0, 6'h3F, 32'hFFFF_FFFF, 32'd0,
              16'hFFFF, 4'hF, 4'hF, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      add_row(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'hFFFF, 4'hF, 4'hF, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, 6'h3F, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      // open, reopen from syn_sent reloads the isn
      add_row(REQ_OPEN, 32'hFFFF_FFFF, 1'b0, 6'h00, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, TYPED, 1'b1, FLAG_SYN, 32'hFFFF_FFFF, 32'd0,
              CONN_SYN_SENT);
      add_row(REQ_OPEN, 32'h1234_5678, 1'b0, 6'h00, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, TYPED, 1'b1, FLAG_SYN, 32'h1234_5678, 32'd0,
              CONN_SYN_SENT);
      // syn-ack with wrong ack, without ack flag, not tcp
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_SYN | FLAG_ACK, 32'd5, 32'd0,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_SYN_SENT);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_SYN, 32'd5, 32'h1234_5679,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_SYN_SENT);
      add_row(REQ_SEGMENT, 32'd0, 1'b0, FLAG_SYN | FLAG_ACK, 32'd5, 32'h1234_5679,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_SYN_SENT);
      // valid syn-ack, remote seq wraps to zero
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_SYN | FLAG_ACK | FLAG_RST | FLAG_URG,
              32'hFFFF_FFFF, 32'h1234_5679, 16'd40, 4'h5, 4'h5,
              TYPED, 1'b1, FLAG_ACK, 32'h1234_5679, 32'd0, CONN_ESTABLISHED);
      // data: largest total length, negative payload, zero-size headers (largest payload)
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_PSH | FLAG_ACK, 32'h0000_0010,
              32'hAAAA_5555, 16'hFFFF, 4'hF, 4'hF, PREDICTED, 1'b0, 6'h00, 32'd0,
              32'd0, CONN_CLOSED);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_PSH | FLAG_ACK, 32'd0, 32'd0,
              16'd0, 4'hF, 4'hF, PREDICTED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, 6'h3E, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
              16'hFFFF, 4'h0, 4'h0, PREDICTED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, 6'h00, 32'd1, 32'd1,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_ESTABLISHED);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_ACK, 32'd1, 32'h5555_5555,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_ESTABLISHED);
      add_row(REQ_UNUSED, 32'd0, 1'b1, FLAG_ACK | FLAG_FIN, 32'd1, 32'd1,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_ESTABLISHED);
      // close from established keeps the numbers
      add_row(REQ_CLOSE, 32'd0, 1'b0, 6'h00, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, PREDICTED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_FIN, 32'd0, 32'd0,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSE_WAIT);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_ACK, 32'd0, 32'd0,
              16'd40, 4'h5, 4'h5, TYPED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      add_row(REQ_CLOSE, 32'd0, 1'b0, 6'h00, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, TYPED, 1'b1, FLAG_FIN | FLAG_ACK, 32'd0, 32'd0,
              CONN_CLOSE_WAIT);
      // open from close_wait does not reload the isn
      add_row(REQ_OPEN, 32'hDEAD_BEEF, 1'b0, 6'h00, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, TYPED, 1'b1, FLAG_SYN, 32'd0, 32'd0, CONN_SYN_SENT);
      // syn-ack carrying data: two words
      add_row(REQ_SEGMENT, 32'd0, 1'b1, 6'h3F, 32'h7FFF_FFFF, 32'd1,
              16'd40, 4'h5, 4'h5, PREDICTED, 1'b0, 6'h00, 32'd0, 32'd0, CONN_CLOSED);
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_ACK | FLAG_FIN, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 16'd40, 4'h5, 4'h5, PREDICTED, 1'b0, 6'h00, 32'd0,
              32'd0, CONN_CLOSED);
      add_row(REQ_OPEN, 32'h8000_0000, 1'b0, 6'h00, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, TYPED, 1'b1, FLAG_SYN, 32'h8000_0000, 32'd0,
              CONN_SYN_SENT);
      // syn-ack carrying fin: handshake ack, then fin ack and closed
      add_row(REQ_SEGMENT, 32'd0, 1'b1, FLAG_SYN | FLAG_ACK | FLAG_FIN, 32'd0,
              32'h8000_0001, 16'd40, 4'h5, 4'h5, PREDICTED, 1'b0, 6'h00, 32'd0,
              32'd0, CONN_CLOSED);
      add_row(REQ_CLOSE, 32'hFFFF_FFFF, 1'b0, 6'h00, 32'd0, 32'd0,
              16'd0, 4'h0, 4'h0, TYPED, 1'b1, FLAG_FIN | FLAG_ACK, 32'hFFFF_FFFF,
              32'd0, CONN_CLOSE_WAIT);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stimulus_table[i])
         send_request(stimulus_table[i].w, stimulus_table[i].typed,
                      stimulus_table[i].want);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         no_stall = (n >= 150 && n < 250);
         if (n == 300) begin
            req_ch.valid <= 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
         end
         w = random_request();
         send_request(w, PREDICTED, none);
      end
      req_ch.valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_replies.size() != 0)
         report_mismatch("replies never returned", 32'd0, pending_replies.size());

      $display("covered %0d requests (%0d table rows), %0d response words checked",
               requests_sent, stimulus_table.size(), words_checked);
      $display("%0d requests gave two words, %0d mismatches", two_word_count,
               mismatch_count);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> files.f
rtl/tcf_pkg.sv
rtl/tcf_req_if.sv
rtl/tcf_rsp_if.sv
rtl/tcf_conn.sv
rtl/tcp_client_connection_fsm.sv
tb/sv/tb_top.sv
